// ===== design/cmts_pkg.sv =====
// ============================================================================
// cmts_pkg
// Shared types and constants of the C-minus token scanner.
// ============================================================================
`default_nettype none

package cmts_pkg;

    // token codes
    localparam logic [4:0] TK_ELSE    = 5'd0;
    localparam logic [4:0] TK_IF      = 5'd1;
    localparam logic [4:0] TK_INT     = 5'd2;
    localparam logic [4:0] TK_RETURN  = 5'd3;
    localparam logic [4:0] TK_VOID    = 5'd4;
    localparam logic [4:0] TK_WHILE   = 5'd5;
    localparam logic [4:0] TK_ID      = 5'd6;
    localparam logic [4:0] TK_NUM     = 5'd7;
    localparam logic [4:0] TK_PLUS    = 5'd8;
    localparam logic [4:0] TK_MINUS   = 5'd9;
    localparam logic [4:0] TK_MULT    = 5'd10;
    localparam logic [4:0] TK_DIV     = 5'd11;
    localparam logic [4:0] TK_LT      = 5'd12;
    localparam logic [4:0] TK_LE      = 5'd13;
    localparam logic [4:0] TK_GT      = 5'd14;
    localparam logic [4:0] TK_GE      = 5'd15;
    localparam logic [4:0] TK_EQ      = 5'd16;
    localparam logic [4:0] TK_NE      = 5'd17;
    localparam logic [4:0] TK_ASSIGN  = 5'd18;
    localparam logic [4:0] TK_SEMI    = 5'd19;
    localparam logic [4:0] TK_COMMA   = 5'd20;
    localparam logic [4:0] TK_LPAR    = 5'd21;
    localparam logic [4:0] TK_RPAR    = 5'd22;
    localparam logic [4:0] TK_LBRK    = 5'd23;
    localparam logic [4:0] TK_RBRK    = 5'd24;
    localparam logic [4:0] TK_LBRC    = 5'd25;
    localparam logic [4:0] TK_RBRC    = 5'd26;
    localparam logic [4:0] TK_COMMENT = 5'd27;
    localparam logic [4:0] TK_EOF     = 5'd28;

    // record kinds
    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    // keyword table, zero padded to six characters
    localparam int KW_NUM = 6;
    localparam int KW_MAX = 6;
    localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX] = '{
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00}
    };
    localparam int KW_LEN [KW_NUM] = '{4, 2, 3, 6, 4, 5};
    localparam logic [4:0] KW_CODE [KW_NUM] = '{
        TK_ELSE, TK_IF, TK_INT, TK_RETURN, TK_VOID, TK_WHILE
    };

    typedef enum logic [3:0] {
        M_START    = 4'd0,
        M_ID       = 4'd1,
        M_NUM      = 4'd2,
        M_SLASH    = 4'd3,
        M_EQ       = 4'd4,
        M_LT       = 4'd5,
        M_GT       = 4'd6,
        M_BANG     = 4'd7,
        M_CMT      = 4'd8,
        M_CMT_STAR = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LEAD,
        ST_TEXT,
        ST_TAIL
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_LEAD,
        SEL_TEXT,
        SEL_TAIL
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      commit;
        logic      idx_clr;
        logic      idx_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic lead_valid;
        logic has_text;
        logic tail_valid;
        logic text_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/cmts_dpath.sv =====
// ============================================================================
// cmts_dpath
// Scanner datapath: input latch, scan mode, word store, token decode and
// output register.
// ============================================================================
`default_nettype none

module cmts_dpath #(
    parameter int WORD_CAP = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  [7:0]           char_in,
    input  wire                  end_of_input,
    input  cmts_pkg::ctrl_cmd_t  cmd,
    output cmts_pkg::dp_status_t status,
    input  wire                  m_axis_tready,
    output logic                 m_axis_tvalid,
    output logic                 m_axis_tuser,
    output logic [15:0]          m_axis_tdata,
    output logic                 m_axis_tlast
);
    import cmts_pkg::*;

    localparam int BUF_LEN = WORD_CAP - 1;
    localparam int IW      = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam int LW      = $clog2(WORD_CAP);

    logic [7:0]    char_reg;
    logic          end_reg;
    mode_t         mode_reg;
    logic [LW-1:0] len_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [7:0]    mem [BUF_LEN];
    logic [7:0]    rd_data_reg;
    logic [7:0]    head_reg [KW_MAX];

    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [4:0]    out_code_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;

    logic          is_letter;
    logic          is_digit;
    mode_t         sc_mode;
    logic          sc_tok_valid;
    logic [4:0]    sc_tok;
    logic          sc_new;

    logic [KW_NUM-1:0] kw_eq;
    logic          kw_hit;
    logic [4:0]    kw_code;
    logic [4:0]    word_code;

    logic          lead_valid;
    logic [4:0]    lead_code;
    logic          lead_word;
    logic          tail_valid;
    logic [4:0]    tail_code;
    mode_t         mode_next;
    logic          new_word;
    logic          append;
    logic          clr_len;
    logic          use_sc;

    logic          slot_free;
    logic          wr_en;
    logic [IW-1:0] wr_addr;

    assign is_letter = ((char_reg >= "a") && (char_reg <= "z")) ||
                       ((char_reg >= "A") && (char_reg <= "Z"));
    assign is_digit  = (char_reg >= "0") && (char_reg <= "9");

    // first character of a token
    always_comb
    begin
        sc_mode      = M_START;
        sc_tok_valid = 1'b0;
        sc_tok       = TK_PLUS;
        sc_new       = 1'b0;
        if (is_letter)
        begin
            sc_mode = M_ID;
            sc_new  = 1'b1;
        end
        else if (is_digit)
        begin
            sc_mode = M_NUM;
            sc_new  = 1'b1;
        end
        else
        begin
            case (char_reg)
                "+": begin sc_tok_valid = 1'b1; sc_tok = TK_PLUS;  end
                "-": begin sc_tok_valid = 1'b1; sc_tok = TK_MINUS; end
                "*": begin sc_tok_valid = 1'b1; sc_tok = TK_MULT;  end
                ";": begin sc_tok_valid = 1'b1; sc_tok = TK_SEMI;  end
                ",": begin sc_tok_valid = 1'b1; sc_tok = TK_COMMA; end
                "(": begin sc_tok_valid = 1'b1; sc_tok = TK_LPAR;  end
                ")": begin sc_tok_valid = 1'b1; sc_tok = TK_RPAR;  end
                "[": begin sc_tok_valid = 1'b1; sc_tok = TK_LBRK;  end
                "]": begin sc_tok_valid = 1'b1; sc_tok = TK_RBRK;  end
                "{": begin sc_tok_valid = 1'b1; sc_tok = TK_LBRC;  end
                "}": begin sc_tok_valid = 1'b1; sc_tok = TK_RBRC;  end
                "/": sc_mode = M_SLASH;
                "=": sc_mode = M_EQ;
                "<": sc_mode = M_LT;
                ">": sc_mode = M_GT;
                "!": sc_mode = M_BANG;
                default: sc_mode = M_START;
            endcase
        end
    end

    // keyword match against the first kept characters
    always_comb
    begin
        for (int i = 0; i < KW_NUM; i++)
        begin
            kw_eq[i] = (int'(len_reg) == KW_LEN[i]);
            for (int k = 0; k < KW_MAX; k++)
            begin
                if ((k < KW_LEN[i]) && (head_reg[k] != KW_TEXT[i][k]))
                begin
                    kw_eq[i] = 1'b0;
                end
            end
        end
        kw_hit  = |kw_eq;
        kw_code = TK_ID;
        for (int i = 0; i < KW_NUM; i++)
        begin
            if (kw_eq[i])
            begin
                kw_code = KW_CODE[i];
            end
        end
    end

    assign word_code = (mode_reg == M_ID) ? (kw_hit ? kw_code : TK_ID) : TK_NUM;

    // results and next state of the item in hand
    always_comb
    begin
        lead_valid = 1'b0;
        lead_code  = TK_DIV;
        lead_word  = 1'b0;
        tail_valid = 1'b0;
        tail_code  = TK_EOF;
        mode_next  = mode_reg;
        new_word   = 1'b0;
        append     = 1'b0;
        clr_len    = 1'b0;
        use_sc     = 1'b0;
        if (end_reg)
        begin
            tail_valid = 1'b1;
            tail_code  = TK_EOF;
            mode_next  = M_START;
            clr_len    = 1'b1;
            case (mode_reg)
                M_ID, M_NUM: lead_word = 1'b1;
                M_SLASH: begin lead_valid = 1'b1; lead_code = TK_DIV;    end
                M_EQ:    begin lead_valid = 1'b1; lead_code = TK_ASSIGN; end
                M_LT:    begin lead_valid = 1'b1; lead_code = TK_LT;     end
                M_GT:    begin lead_valid = 1'b1; lead_code = TK_GT;     end
                default: lead_valid = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                M_ID, M_NUM:
                begin
                    if ((mode_reg == M_ID) ? is_letter : is_digit)
                    begin
                        append = (int'(len_reg) < BUF_LEN);
                    end
                    else
                    begin
                        lead_word = 1'b1;
                        use_sc    = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (char_reg == "*")
                    begin
                        mode_next = M_CMT;
                    end
                    else
                    begin
                        lead_valid = 1'b1;
                        lead_code  = TK_DIV;
                        use_sc     = 1'b1;
                    end
                end
                M_EQ, M_LT, M_GT:
                begin
                    if (char_reg == "=")
                    begin
                        tail_valid = 1'b1;
                        tail_code  = (mode_reg == M_EQ) ? TK_EQ :
                                     (mode_reg == M_LT) ? TK_LE : TK_GE;
                        mode_next  = M_START;
                    end
                    else
                    begin
                        lead_valid = 1'b1;
                        lead_code  = (mode_reg == M_EQ) ? TK_ASSIGN :
                                     (mode_reg == M_LT) ? TK_LT : TK_GT;
                        use_sc     = 1'b1;
                    end
                end
                M_BANG:
                begin
                    if (char_reg == "=")
                    begin
                        tail_valid = 1'b1;
                        tail_code  = TK_NE;
                        mode_next  = M_START;
                    end
                    else
                    begin
                        use_sc = 1'b1;
                    end
                end
                M_CMT:
                begin
                    if (char_reg == "*")
                    begin
                        mode_next = M_CMT_STAR;
                    end
                end
                M_CMT_STAR:
                begin
                    if (char_reg == "/")
                    begin
                        tail_valid = 1'b1;
                        tail_code  = TK_COMMENT;
                        mode_next  = M_START;
                    end
                    else if (char_reg != "*")
                    begin
                        mode_next = M_CMT;
                    end
                end
                default: use_sc = 1'b1;
            endcase
        end
        if (use_sc)
        begin
            mode_next  = sc_mode;
            tail_valid = sc_tok_valid;
            tail_code  = sc_tok;
            new_word   = sc_new;
        end
        if (lead_word)
        begin
            lead_valid = 1'b1;
            lead_code  = word_code;
            clr_len    = 1'b1;
        end
    end

    assign slot_free = !out_valid_reg || m_axis_tready;

    assign status.slot_free  = slot_free;
    assign status.lead_valid = lead_valid;
    assign status.has_text   = lead_word && !((mode_reg == M_ID) && kw_hit);
    assign status.tail_valid = tail_valid;
    assign status.text_done  = ((LW'(idx_reg) + LW'(1)) == len_reg);

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign wr_en   = cmd.commit && (new_word || append);
    assign wr_addr = new_word ? '0 : len_reg[IW-1:0];

    // word store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= char_reg;
        end
        rd_data_reg <= mem[idx_next];
    end

    // copy of the leading characters for keyword matching
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < KW_MAX; k++)
        begin
            if (wr_en && (int'(wr_addr) == k))
            begin
                head_reg[k] <= char_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= char_in;
            end_reg  <= end_of_input;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_START;
            len_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.commit)
            begin
                mode_reg <= mode_next;
                if (new_word)
                begin
                    len_reg <= LW'(1);
                end
                else if (clr_len)
                begin
                    len_reg <= '0;
                end
                else if (append)
                begin
                    len_reg <= len_reg + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && slot_free)
        begin
            out_last_reg <= cmd.last;
            case (cmd.sel)
                SEL_TEXT:
                begin
                    out_kind_reg <= KIND_TEXT;
                    out_code_reg <= word_code;
                    out_char_reg <= rd_data_reg;
                end
                SEL_TAIL:
                begin
                    out_kind_reg <= KIND_TOKEN;
                    out_code_reg <= tail_code;
                    out_char_reg <= 8'h00;
                end
                default:
                begin
                    out_kind_reg <= KIND_TOKEN;
                    out_code_reg <= lead_code;
                    out_char_reg <= 8'h00;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {3'b000, out_char_reg, out_code_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/cmts_ctrl.sv =====
// ============================================================================
// cmts_ctrl
// Scanner controller: takes a request, then steps through the lead token,
// the lexeme text and the tail token, one result per cycle unless stalled.
// ============================================================================
`default_nettype none

module cmts_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  cmts_pkg::dp_status_t status,
    output cmts_pkg::ctrl_cmd_t  cmd
);
    import cmts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_LEAD;
        cmd.last      = 1'b0;
        cmd.commit    = 1'b0;
        cmd.idx_clr   = 1'b0;
        cmd.idx_inc   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.lead_valid)
                begin
                    state_next = ST_LEAD;
                end
                else if (status.tail_valid)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LEAD:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_LEAD;
                cmd.last = !status.has_text && !status.tail_valid;
                if (status.slot_free)
                begin
                    if (status.has_text)
                    begin
                        state_next = ST_TEXT;
                    end
                    else if (status.tail_valid)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TEXT:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_TEXT;
                cmd.last = status.text_done && !status.tail_valid;
                if (status.slot_free)
                begin
                    if (!status.text_done)
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                    else if (status.tail_valid)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_TAIL;
                cmd.last = 1'b1;
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/c_minus_token_scanner_top.sv =====
// ============================================================================
// c_minus_token_scanner_top
// C-minus lexical scanner: source characters in, token and text records out.
// ============================================================================
// Slave channel: one source byte per request in tdata, tuser set marks end
// of input (tdata then ignored). Master channel: one record per request;
// tuser 0 is a token record, 1 a lexeme character of the preceding
// identifier or number; tlast closes the records caused by one input.
// Sequence: an input request is taken in the idle state and decoded in the
// evaluate state; each of its results then leaves in turn through the output
// register; a character that continues a word or is dropped has no results.
// Unless stalled, the controller sequences one result per cycle through the
// output register; lexeme text comes from the word store's single read port.
// A number or non-keyword identifier of n kept characters gives n + 1 records.
// The slave side is ready again as soon as the last result is loaded into
// the output register, even while that record still waits.
// A stalled receiver holds the record in the output register and the
// sequencer waits; nothing is dropped.
// Reset clears the scan mode to the start state, the word length to zero
// and empties the output register; the word store needs no clearing.
// ============================================================================
`default_nettype none

module c_minus_token_scanner_top #(
    parameter int WORD_CAP = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire         s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] token_code, [12:5] text_char, zero above
    output logic        m_axis_tuser,   // [0] record_kind
    output logic        m_axis_tlast
);
    import cmts_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    cmts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    cmts_dpath #(
        .WORD_CAP (WORD_CAP)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_in       (s_axis_tdata),
        .end_of_input  (s_axis_tuser),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== design/cmts_checker.sv =====
// ============================================================================
// cmts_checker
// Port-level checks on the scanner, bound to the top level.
// ============================================================================
`default_nettype none

module cmts_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);
    import cmts_pkg::*;

    // stalled record holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output record changed while stalled");

    // one request at a time: decode cycle follows every accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken during decode");

    // text records belong to an identifier or number
    a_text_owner: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_TEXT) |->
            (m_axis_tdata[4:0] == TK_ID) || (m_axis_tdata[4:0] == TK_NUM))
        else $error("text record with bad owner code");

    // token records carry no character
    a_token_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_TOKEN) |->
            (m_axis_tdata[15:5] == 11'd0))
        else $error("token record with nonzero character");

    // end of file always closes its input's records
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_TOKEN) &&
            (m_axis_tdata[4:0] == TK_EOF) |-> m_axis_tlast)
        else $error("end-of-file token not marked last");

endmodule

bind c_minus_token_scanner_top cmts_checker u_cmts_checker (.*);

`default_nettype wire
